/* rtl/wsc_pkg.sv */
// ----------------------------------------------------------------------------
// Weekly schedule countdown package
// Shared constants, command codes and the schedule entry layout.
// ----------------------------------------------------------------------------
package wsc_pkg;

   localparam int LED_COUNT   = 24;
   localparam int MAX_ENTRIES = 16;

   localparam int LED_W = 5;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam int WEEK_SEC      = 604800;
   localparam int WEEK_SEC_PLUS = 604801;
   localparam int DAY_SEC       = 86400;
   localparam int HOUR_SEC      = 3600;
   localparam int MIN_SEC       = 60;

   localparam int SEC_W  = 20;
   localparam int SUM_W  = SEC_W + 1;
   localparam int QW     = $clog2(LED_COUNT + 1);
   localparam int PROD_W = SEC_W + QW;

   localparam logic [3:0] OFF_CODE = 4'd15;
   localparam logic [6:0] NO_MINUTE = 7'd127;

   typedef enum logic [2:0] {
      CMD_WRITE  = 3'd0,
      CMD_TICK   = 3'd1,
      CMD_EVAL   = 3'd2,
      CMD_MINUTE = 3'd3,
      CMD_APPLY  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [3:0] color;
      logic       enabled;
      logic       countdown;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [6:0] days;
   } entry_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [SEC_W-1:0] time_sec(input logic [2:0] d, input logic [4:0] h,
                                                  input logic [5:0] m, input logic [5:0] s);
      logic [31:0] t;
      t = 32'(d) * 32'(DAY_SEC) + 32'(h) * 32'(HOUR_SEC) + 32'(m) * 32'(MIN_SEC) + 32'(s);
      return t[SEC_W-1:0];
   endfunction

endpackage

/* rtl/wsc_if.sv */
// ----------------------------------------------------------------------------
// Weekly schedule countdown channels
// Request and response channels with valid and ready handshake.
// ----------------------------------------------------------------------------
interface wsc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [3:0] entry_index;
   logic [6:0] day_mask;
   logic [2:0] weekday;
   logic [4:0] hour;
   logic [5:0] minute;
   logic [5:0] second;
   logic       countdown_flag;
   logic       enabled_flag;
   logic [3:0] color_code;
   logic       clock_valid;

   modport source (output valid, command, entry_index, day_mask, weekday, hour, minute,
                   second, countdown_flag, enabled_flag, color_code, clock_valid,
                   input ready);
   modport sink (input valid, command, entry_index, day_mask, weekday, hour, minute,
                 second, countdown_flag, enabled_flag, color_code, clock_valid,
                 output ready);
endinterface

interface wsc_rsp_if;
   logic       valid;
   logic       ready;
   logic       redraw;
   logic [4:0] leds_lit;
   logic [3:0] color_mode;
   logic       color_applied;

   modport source (output valid, redraw, leds_lit, color_mode, color_applied, input ready);
   modport sink (input valid, redraw, leds_lit, color_mode, color_applied, output ready);
endinterface

/* rtl/wsc_div.sv */
// ----------------------------------------------------------------------------
// Weekly schedule countdown divider
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  wsc_pkg::div_ctrl_type        ctrl,
   input  logic [wsc_pkg::PROD_W-1:0]   dividend,
   input  logic [wsc_pkg::SUM_W-1:0]    divisor,
   output wsc_pkg::div_stat_type        stat,
   output logic [wsc_pkg::QW-1:0]       quotient
);
   import wsc_pkg::*;

   localparam int RW  = SUM_W + QW;
   localparam int QSW = $clog2(QW + 1);

   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [QSW-1:0]    step_ff, step_in;
   logic [QW-1:0]     q_ff, q_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [RW-1:0]     trial;
   logic [RW-1:0]     rem_ext;
   logic              fits;

   always_comb begin
      trial   = RW'(dvs_ff) << step_ff;
      rem_ext = RW'(rem_ff);
      fits    = rem_ext >= trial;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      q_in    = q_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         step_in = QSW'(QW - 1);
         q_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = PROD_W'(rem_ext - trial);
         end
         q_in = (q_ff << 1) | QW'(fits);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - QSW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

/* rtl/weekly_schedule_countdown_unit.sv */
// ----------------------------------------------------------------------------
// Weekly schedule countdown unit
// Schedule table with countdown, evaluate, minute check and apply commands.
// ----------------------------------------------------------------------------
// Write, apply and ignored requests go from S_IDLE through S_DONE to the response register.
// Countdown tick and evaluate scan 7 days of each entry in use, one per cycle;
// a countdown tick also runs the divider when the chosen entry counts down.
// The minute check scans one entry per cycle.
// One request is in work at a time; the response register frees the input.
// Synchronous reset clears control state; the schedule table is not cleared.
module weekly_schedule_countdown_unit (
   input  logic       clock,
   input  logic       reset,
   wsc_req_if.sink    req_chan,
   wsc_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data
);
   import wsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_RESOLVE, S_DIV, S_DIV_WAIT, S_DONE
   } state_type;

   typedef enum logic [1:0] { M_TICK, M_EVAL, M_MINUTE } mode_type;

   state_type         state_ff;
   mode_type          mode_ff;
   entry_type         table_ff [MAX_ENTRIES];
   logic [4:0]        count_ff;
   logic [3:0]        color_ff;
   logic [LED_W-1:0]  lit_ff;
   logic [6:0]        last_min_ff;
   logic [SEC_W-1:0]  now_ff;
   logic [2:0]        wd_ff;
   logic [4:0]        hr_ff;
   logic [5:0]        mn_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [2:0]        day_ff;
   logic [SEC_W-1:0]  best_e_ff;
   logic [SEC_W-1:0]  best_r_ff;
   logic              found_ff;
   logic              act_cd_ff;
   logic [3:0]        act_color_ff;
   logic              redraw_ff;
   logic              applied_ff;
   logic              rsp_valid_ff;
   logic              rsp_redraw_ff;
   logic [LED_W-1:0]  rsp_leds_ff;
   logic [3:0]        rsp_color_ff;
   logic              rsp_applied_ff;

   logic [CNT_W-1:0]  n_use;
   logic              time_ok;
   logic              accept;
   entry_type         ent;
   logic              ent_ok;
   logic [SEC_W-1:0]  s_sec;
   logic [SUM_W-1:0]  el_raw;
   logic [SEC_W-1:0]  el;
   logic [SEC_W-1:0]  rm;
   logic              last_idx;
   logic              min_match;
   logic [LED_W-1:0]  want;
   logic [QW-1:0]     quotient;
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;

   assign n_use   = (count_ff > 5'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(count_ff);
   assign time_ok = req_chan.clock_valid && req_chan.weekday <= 3'd6 && req_chan.hour <= 5'd23
                    && req_chan.minute <= 6'd59 && req_chan.second <= 6'd59;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      ent       = table_ff[idx_ff];
      ent_ok    = ent.hour <= 5'd23 && ent.minute <= 6'd59;
      s_sec     = time_sec(day_ff, ent.hour, ent.minute, 6'd0);
      el_raw    = SUM_W'(now_ff) - SUM_W'(s_sec);
      el        = el_raw[SEC_W] ? SEC_W'(el_raw + SUM_W'(WEEK_SEC)) : el_raw[SEC_W-1:0];
      rm        = (s_sec > now_ff) ? SEC_W'(s_sec - now_ff)
                                   : SEC_W'(SUM_W'(s_sec) + SUM_W'(WEEK_SEC) - SUM_W'(now_ff));
      last_idx  = (idx_ff == IDX_W'(n_use - CNT_W'(1)));
      min_match = ent_ok && ent.enabled && ent.days[wd_ff] && ent.hour == hr_ff
                  && ent.minute == mn_ff;
      want      = (LED_COUNT > int'(quotient) + 1) ? LED_W'(LED_COUNT - int'(quotient))
                                                     : LED_W'(1);
      div_ctrl.start = (state_ff == S_DIV);
   end

   wsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (PROD_W'(best_e_ff) * PROD_W'(LED_COUNT)),
      .divisor  (SUM_W'(best_e_ff) + SUM_W'(best_r_ff)),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (accept && req_chan.command == CMD_WRITE && 32'(req_chan.entry_index) < MAX_ENTRIES) begin
         table_ff[IDX_W'(req_chan.entry_index)] <= '{color: req_chan.color_code,
            enabled: req_chan.enabled_flag, countdown: req_chan.countdown_flag,
            minute: req_chan.minute, hour: req_chan.hour, days: req_chan.day_mask};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_TICK;
         count_ff     <= '0;
         color_ff     <= OFF_CODE;
         lit_ff       <= LED_W'(LED_COUNT);
         last_min_ff  <= NO_MINUTE;
         rsp_valid_ff <= 1'b0;
         redraw_ff    <= 1'b0;
         applied_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  wd_ff      <= req_chan.weekday;
                  hr_ff      <= req_chan.hour;
                  mn_ff      <= req_chan.minute;
                  idx_ff     <= '0;
                  day_ff     <= '0;
                  best_e_ff  <= SEC_W'(WEEK_SEC_PLUS);
                  best_r_ff  <= SEC_W'(WEEK_SEC_PLUS);
                  found_ff   <= 1'b0;
                  redraw_ff  <= 1'b0;
                  applied_ff <= 1'b0;
                  state_ff   <= S_DONE;
                  case (req_chan.command)
                     CMD_TICK: begin
                        now_ff  <= time_sec(req_chan.weekday, req_chan.hour,
                                            req_chan.minute, req_chan.second);
                        mode_ff <= M_TICK;
                        if (color_ff != OFF_CODE && time_ok && n_use != '0) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     CMD_EVAL: begin
                        now_ff  <= time_sec(req_chan.weekday, req_chan.hour,
                                            req_chan.minute, 6'd0);
                        mode_ff <= M_EVAL;
                        if (n_use == '0) begin
                           color_ff   <= OFF_CODE;
                           lit_ff     <= LED_W'(LED_COUNT);
                           redraw_ff  <= 1'b1;
                           applied_ff <= 1'b1;
                        end else if (time_ok) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     CMD_MINUTE: begin
                        mode_ff <= M_MINUTE;
                        if (time_ok && {1'b0, req_chan.minute} != last_min_ff) begin
                           last_min_ff <= {1'b0, req_chan.minute};
                           if (n_use != '0) begin
                              state_ff <= S_SCAN;
                           end
                        end
                     end
                     CMD_APPLY: begin
                        color_ff   <= req_chan.color_code;
                        lit_ff     <= LED_W'(LED_COUNT);
                        redraw_ff  <= 1'b1;
                        applied_ff <= 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (mode_ff == M_MINUTE) begin
                  if (min_match) begin
                     found_ff     <= 1'b1;
                     act_color_ff <= ent.color;
                  end
                  idx_ff <= idx_ff + IDX_W'(1);
                  if (last_idx) begin
                     state_ff <= S_RESOLVE;
                  end
               end else begin
                  if (ent_ok && ent.days[day_ff]) begin
                     if (el < best_e_ff) begin
                        best_e_ff    <= el;
                        found_ff     <= 1'b1;
                        act_cd_ff    <= ent.countdown;
                        act_color_ff <= ent.color;
                     end
                     if (rm < best_r_ff) begin
                        best_r_ff <= rm;
                     end
                  end
                  if (day_ff == 3'd6) begin
                     day_ff <= '0;
                     idx_ff <= idx_ff + IDX_W'(1);
                     if (last_idx) begin
                        state_ff <= S_RESOLVE;
                     end
                  end else begin
                     day_ff <= day_ff + 3'd1;
                  end
               end
            end
            S_RESOLVE: begin
               state_ff <= S_DONE;
               if (mode_ff == M_TICK) begin
                  if (found_ff) begin
                     if (act_cd_ff) begin
                        state_ff <= S_DIV;
                     end else if (lit_ff != LED_W'(LED_COUNT)) begin
                        lit_ff    <= LED_W'(LED_COUNT);
                        redraw_ff <= 1'b1;
                     end
                  end
               end else if (mode_ff == M_EVAL || found_ff) begin
                  color_ff   <= found_ff ? act_color_ff : OFF_CODE;
                  lit_ff     <= LED_W'(LED_COUNT);
                  redraw_ff  <= 1'b1;
                  applied_ff <= 1'b1;
               end
            end
            S_DIV: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_stat.done) begin
                  state_ff <= S_DONE;
                  if (want != lit_ff) begin
                     lit_ff    <= want;
                     redraw_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_redraw_ff  <= redraw_ff;
                  rsp_leds_ff    <= lit_ff;
                  rsp_color_ff   <= color_ff;
                  rsp_applied_ff <= applied_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.redraw        = rsp_redraw_ff;
   assign rsp_chan.leds_lit      = rsp_leds_ff;
   assign rsp_chan.color_mode    = rsp_color_ff;
   assign rsp_chan.color_applied = rsp_applied_ff;

endmodule

/* rtl/wsc_checker.sv */
// ----------------------------------------------------------------------------
// Weekly schedule countdown checker
// Port-level properties of the response channel.
// ----------------------------------------------------------------------------
module wsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_redraw,
   input logic [4:0] rsp_leds_lit,
   input logic       rsp_color_applied
);
   import wsc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_lit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_leds_lit != 5'd0 && 32'(rsp_leds_lit) <= LED_COUNT)
      else $error("lit count out of range");

   a_apply_redraw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_applied |-> rsp_redraw)
      else $error("applied color without redraw");

   a_apply_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_applied |-> 32'(rsp_leds_lit) == LED_COUNT)
      else $error("applied color without full ring");

endmodule

bind weekly_schedule_countdown_unit wsc_checker u_wsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_redraw        (rsp_chan.redraw),
   .rsp_leds_lit      (rsp_chan.leds_lit),
   .rsp_color_applied (rsp_chan.color_applied)
);

/* dv/wsc_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekly schedule countdown testbench
// Drives schedule writes, countdown ticks, evaluations, minute checks and
// direct color requests through random handshake gaps. A scoreboard class
// predicts every response from its own copy of the table and checks each one.
// ----------------------------------------------------------------------------
module tb;
   import wsc_pkg::*;

   localparam string PASS_MSG = "[ OK ] regression clean";

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] entry_index;
      logic [6:0] day_mask;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       countdown_flag;
      logic       enabled_flag;
      logic [3:0] color_code;
      logic       clock_valid;
   } request_type;

   typedef struct packed {
      logic       redraw;
      logic [4:0] leds_lit;
      logic [3:0] color_mode;
      logic       color_applied;
   } response_type;

   class schedule_scoreboard;
      entry_type    table_copy [MAX_ENTRIES];
      logic [4:0]   entry_limit;
      logic [3:0]   color_now;
      logic [4:0]   lit_now;
      logic [6:0]   minute_seen;
      response_type pending [$];
      int           errors;
      int           checked;

      function new();
         entry_limit = 0;
         color_now   = OFF_CODE;
         lit_now     = LED_W'(LED_COUNT);
         minute_seen = NO_MINUTE;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_count(logic [4:0] v);
         entry_limit = v;
      endfunction

      function void paint(logic [3:0] code, ref response_type r);
         color_now = code;
         lit_now = LED_W'(LED_COUNT);
         r.redraw = 1'b1;
         r.color_applied = 1'b1;
      endfunction

      function void note_request(request_type q);
         response_type r;
         int           n;
         longint       now;
         longint       start;
         longint       el;
         longint       rm;
         longint       best_e;
         longint       best_r;
         longint       k;
         int           act;
         logic [4:0]   want;
         bit           time_ok;
         entry_type    e;
         r = '0;
         n = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_limit);
         time_ok = q.clock_valid && q.weekday <= 6 && q.hour <= 23 && q.minute <= 59
            && q.second <= 59;
         case (q.command)
            CMD_WRITE: begin
               table_copy[q.entry_index] = '{color: q.color_code, enabled: q.enabled_flag,
                  countdown: q.countdown_flag, minute: q.minute, hour: q.hour,
                  days: q.day_mask};
            end
            CMD_TICK: begin
               if (color_now != OFF_CODE && time_ok && n > 0) begin
                  now = q.weekday * 86400 + q.hour * 3600 + q.minute * 60 + q.second;
                  best_e = WEEK_SEC_PLUS;
                  best_r = WEEK_SEC_PLUS;
                  act = -1;
                  for (int i = 0; i < n; i++) begin
                     e = table_copy[i];
                     if (e.hour > 23 || e.minute > 59) continue;
                     for (int d = 0; d < 7; d++) begin
                        if (!e.days[d]) continue;
                        start = d * 86400 + e.hour * 3600 + e.minute * 60;
                        el = now - start;
                        if (el < 0) el += WEEK_SEC;
                        if (el < best_e) begin
                           best_e = el;
                           act = i;
                        end
                        rm = start - now;
                        if (rm <= 0) rm += WEEK_SEC;
                        if (rm < best_r) best_r = rm;
                     end
                  end
                  if (act >= 0) begin
                     if (!table_copy[act].countdown) begin
                        want = LED_W'(LED_COUNT);
                     end else begin
                        k = LED_COUNT - (best_e * LED_COUNT) / (best_e + best_r);
                        if (k < 1) k = 1;
                        want = LED_W'(k);
                     end
                     if (want != lit_now) begin
                        lit_now = want;
                        r.redraw = 1'b1;
                     end
                  end
               end
            end
            CMD_EVAL: begin
               if (n == 0) begin
                  paint(OFF_CODE, r);
               end else if (time_ok) begin
                  now = q.weekday * 1440 + q.hour * 60 + q.minute;
                  best_e = 10081;
                  act = -1;
                  for (int i = 0; i < n; i++) begin
                     e = table_copy[i];
                     if (e.hour > 23 || e.minute > 59) continue;
                     for (int d = 0; d < 7; d++) begin
                        if (!e.days[d]) continue;
                        el = now - (d * 1440 + e.hour * 60 + e.minute);
                        if (el < 0) el += 10080;
                        if (el < best_e) begin
                           best_e = el;
                           act = i;
                        end
                     end
                  end
                  paint((act >= 0) ? table_copy[act].color : OFF_CODE, r);
               end
            end
            CMD_MINUTE: begin
               if (time_ok && 7'(q.minute) != minute_seen) begin
                  minute_seen = 7'(q.minute);
                  for (int i = 0; i < n; i++) begin
                     e = table_copy[i];
                     if (e.hour <= 23 && e.minute <= 59 && e.enabled && e.days[q.weekday]
                        && e.hour == q.hour && e.minute == q.minute)
                        paint(e.color, r);
                  end
               end
            end
            CMD_APPLY: paint(q.color_code, r);
            default: ;
         endcase
         r.leds_lit = lit_now;
         r.color_mode = color_now;
         pending.push_back(r);
      endfunction

      function void check_response(response_type got);
         response_type want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %p", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.redraw !== want.redraw) begin
            errors++;
            $display("%0t: redraw expected %0d actual %0d", $time, want.redraw, got.redraw);
         end
         if (got.leds_lit !== want.leds_lit) begin
            errors++;
            $display("%0t: leds_lit expected %0d actual %0d", $time, want.leds_lit,
               got.leds_lit);
         end
         if (got.color_mode !== want.color_mode) begin
            errors++;
            $display("%0t: color_mode expected %0d actual %0d", $time, want.color_mode,
               got.color_mode);
         end
         if (got.color_applied !== want.color_applied) begin
            errors++;
            $display("%0t: color_applied expected %0d actual %0d", $time,
               want.color_applied, got.color_applied);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [4:0] csr_write_data;
   bit   calm;
   schedule_scoreboard board;

   wsc_req_if req_chan ();
   wsc_rsp_if rsp_chan ();

   weekly_schedule_countdown_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_response('{rsp_chan.redraw, rsp_chan.leds_lit, rsp_chan.color_mode,
               rsp_chan.color_applied});
         rsp_chan.ready <= calm || ($urandom_range(99) >= 14);
      end
   end

   task automatic send(request_type q);
      while (!calm && $urandom_range(99) < 14) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.command        <= q.command;
      req_chan.entry_index    <= q.entry_index;
      req_chan.day_mask       <= q.day_mask;
      req_chan.weekday        <= q.weekday;
      req_chan.hour           <= q.hour;
      req_chan.minute         <= q.minute;
      req_chan.second         <= q.second;
      req_chan.countdown_flag <= q.countdown_flag;
      req_chan.enabled_flag   <= q.enabled_flag;
      req_chan.color_code     <= q.color_code;
      req_chan.clock_valid    <= q.clock_valid;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_count(logic [4:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      board.set_count(v);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic request_type random_request(bit valid_time, int lim);
      request_type q;
      q = request_type'({$urandom, $urandom});
      q.command = 3'($urandom_range(4));
      if ($urandom_range(19) == 0) q.command = 3'($urandom_range(7, 5));
      if (valid_time) begin
         q.weekday = 3'($urandom_range(6));
         q.hour = 5'($urandom_range(23));
         q.minute = 6'($urandom_range(59));
         q.second = 6'($urandom_range(59));
         q.clock_valid = ($urandom_range(15) != 0);
      end
      if (q.command == CMD_WRITE && $urandom_range(3) != 0)
         q.entry_index = 4'($urandom_range(lim - 1));
      return q;
   endfunction

   function automatic request_type directed(logic [2:0] c, logic [3:0] i, logic [6:0] dm,
      logic [2:0] wd, logic [4:0] h, logic [5:0] m, logic [5:0] s, logic cd, logic en,
      logic [3:0] col, logic cv);
      return '{c, i, dm, wd, h, m, s, cd, en, col, cv};
   endfunction

   initial begin
      request_type q;
      int          lim;
      board = new();
      calm = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.command = '0;
      req_chan.entry_index = '0;
      req_chan.day_mask = '0;
      req_chan.weekday = '0;
      req_chan.hour = '0;
      req_chan.minute = '0;
      req_chan.second = '0;
      req_chan.countdown_flag = 1'b0;
      req_chan.enabled_flag = 1'b0;
      req_chan.color_code = '0;
      req_chan.clock_valid = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part with an empty table first, then a small written table.
      send(directed(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(directed(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_WRITE, 0, 7'h7F, 0, 0, 0, 0, 1, 1, 4'd3, 1));
      send(directed(CMD_WRITE, 1, 7'h40, 0, 23, 59, 0, 0, 1, 4'd9, 1));
      send(directed(CMD_WRITE, 2, 7'h01, 0, 31, 63, 0, 1, 1, 4'd5, 1));
      send(directed(CMD_WRITE, 3, 7'h00, 0, 12, 30, 0, 1, 0, 4'd7, 1));
      write_count(4);
      send(directed(CMD_EVAL, 0, 0, 3, 12, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_TICK, 0, 0, 3, 12, 0, 30, 0, 0, 0, 1));
      send(directed(CMD_TICK, 0, 0, 6, 23, 59, 59, 0, 0, 0, 1));
      send(directed(CMD_TICK, 0, 0, 7, 12, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_EVAL, 0, 0, 2, 24, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_MINUTE, 0, 0, 6, 23, 59, 0, 0, 0, 0, 1));
      send(directed(CMD_MINUTE, 0, 0, 6, 23, 59, 0, 0, 0, 0, 1));
      send(directed(CMD_MINUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(directed(CMD_MINUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, 0, OFF_CODE, 1));
      send(directed(CMD_TICK, 0, 0, 1, 1, 1, 1, 0, 0, 0, 1));
      send(directed(CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, 0, 4'd12, 1));
      send(directed(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send(directed(CMD_WRITE, 4'd15, 7'h7F, 6, 23, 59, 59, 1, 1, 4'd15, 1));

      // Fill every entry so any count is safe, then random phases.
      write_count(0);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         q = random_request(1, MAX_ENTRIES);
         q.command = CMD_WRITE;
         q.entry_index = 4'(i);
         q.hour = 5'($urandom_range(23));
         q.minute = 6'($urandom_range(59));
         send(q);
      end
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: lim = 16;
            1: lim = 1;
            2: lim = 31;
            3: lim = 0;
            default: lim = $urandom_range(17);
         endcase
         write_count(5'(lim));
         calm = (phase == 4);
         for (int k = 0; k < 150; k++) begin
            q = random_request($urandom_range(9) != 0, (lim > 0) ? MAX_ENTRIES : 1);
            if (q.command == CMD_WRITE && $urandom_range(4) == 0) q.hour = 5'($urandom);
            send(q);
            if (k == 75) drain();
         end
         calm = 1'b0;
      end
      drain();
      $display("Covered %0d responses over entry counts 0, 1, 16, 31 and random ones,",
         board.checked);
      $display("with all five commands, bad times and handshake stalls on both sides.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display(PASS_MSG);
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/wsc_pkg.sv
rtl/wsc_if.sv
rtl/wsc_div.sv
rtl/weekly_schedule_countdown_unit.sv
rtl/wsc_checker.sv
dv/wsc_tb.sv
